// ===== rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg: shared types for the sprite DMA channel
// Action codes and the input / result transfer payload structs.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // Item action codes
  typedef enum logic [1:0] {
    ActDma   = 2'd0,
    ActPos   = 2'd1,
    ActCtrl  = 2'd2,
    ActImage = 2'd3
  } sdc_action_e;

  // Input transfer payload
  typedef struct packed {
    sdc_action_e action;
    logic [15:0] word;
    logic        slot;
    logic [8:0]  line;
    logic        first_line;
  } sdc_in_t;

  // Result transfer payload
  typedef struct packed {
    logic        fetch_taken;
    logic        armed;
    logic        attach;
    logic [8:0]  horiz_start;
    logic [15:0] image_lo;
    logic [15:0] image_hi;
  } sdc_out_t;

endpackage

// ===== rtl/sprite_dma_channel_top.sv =====
// ----------------------------------------------------------------------------
// sprite_dma_channel_top: one sprite DMA channel
// Pipeline: the input transfer is captured in the input reg, and its result is
// registered in the result reg before the result transfer.
// Throughput: one item per cycle; a held result stalls the input reg and input.
// Reset: asynchronous active low; clears the valid flags of both stages and all sprite state.
// ----------------------------------------------------------------------------
module sprite_dma_channel_top import sdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sdc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sdc_out_t out_data_o
);

  logic     item_valid;
  logic     res_ready;
  logic     advance;
  sdc_in_t  item;
  sdc_out_t result;

  // Item moves from input reg to result reg, updating state
  assign advance = item_valid && res_ready;

  sdc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (advance),
    .item_o       (item)
  );

  sdc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item),
    .result_o (result)
  );

  sdc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_ready_o (res_ready),
    .res_i       (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/sdc_in_stage.sv =====
// ----------------------------------------------------------------------------
// sdc_in_stage: input register
// Captures one input transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module sdc_in_stage import sdc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sdc_in_t in_data_i,
  output logic    item_valid_o,
  input  logic    item_take_i,
  output sdc_in_t item_o
);

  logic    valid_q;
  sdc_in_t data_q;

  // Free slot, or the held item leaves this cycle
  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

// ===== rtl/sdc_core.sv =====
// ----------------------------------------------------------------------------
// sdc_core: sprite channel state and update logic
// Holds position, control, arm and image registers; applies one item when
// enabled and presents the resulting outputs.
// ----------------------------------------------------------------------------
module sdc_core import sdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  sdc_in_t  item_i,
  output sdc_out_t result_o
);

  logic [8:0]  vstart_q, vstart_d;
  logic [8:0]  vstop_q, vstop_d;
  logic [8:0]  hpos_q, hpos_d;
  logic        attach_q, attach_d;
  logic        armed_q, armed_d;
  logic [15:0] img_lo_q, img_lo_d;
  logic [15:0] img_hi_q, img_hi_d;
  logic        taken;
  logic        armed_tmp;

  // Next state for one item
  always_comb begin
    vstart_d  = vstart_q;
    vstop_d   = vstop_q;
    hpos_d    = hpos_q;
    attach_d  = attach_q;
    armed_d   = armed_q;
    img_lo_d  = img_lo_q;
    img_hi_d  = img_hi_q;
    taken     = 1'b0;
    armed_tmp = armed_q || (item_i.line == vstart_q);
    case (item_i.action)
      ActDma: begin
        if ((item_i.line == vstop_q) || item_i.first_line) begin
          // Reload line: slot picks control or position word
          if (item_i.slot) begin
            hpos_d[0]   = item_i.word[0];
            vstop_d     = {item_i.word[1], item_i.word[15:8]};
            vstart_d[8] = item_i.word[2];
            attach_d    = item_i.word[7];
            armed_d     = 1'b0;
          end else begin
            vstart_d[7:0] = item_i.word[15:8];
            hpos_d[8:1]   = item_i.word[7:0];
          end
          taken = 1'b1;
        end else begin
          // Start line arms; armed sprite takes image word 1-slot
          armed_d = armed_tmp;
          if (armed_tmp) begin
            if (item_i.slot) begin
              img_lo_d = item_i.word;
            end else begin
              img_hi_d = item_i.word;
            end
            taken = 1'b1;
          end
        end
      end
      ActPos: begin
        vstart_d[7:0] = item_i.word[15:8];
        hpos_d[8:1]   = item_i.word[7:0];
      end
      ActCtrl: begin
        hpos_d[0]   = item_i.word[0];
        vstop_d     = {item_i.word[1], item_i.word[15:8]};
        vstart_d[8] = item_i.word[2];
        attach_d    = item_i.word[7];
        armed_d     = 1'b0;
      end
      ActImage: begin
        // Writing image word 0 arms the sprite
        if (item_i.slot) begin
          img_hi_d = item_i.word;
        end else begin
          img_lo_d = item_i.word;
          armed_d  = 1'b1;
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase
  end

  // Result reflects state after this item
  always_comb begin
    result_o.fetch_taken = taken;
    result_o.armed       = armed_d;
    result_o.attach      = attach_d;
    result_o.horiz_start = hpos_d;
    result_o.image_lo    = img_lo_d;
    result_o.image_hi    = img_hi_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vstart_q <= '0;
      vstop_q  <= '0;
      hpos_q   <= '0;
      attach_q <= 1'b0;
      armed_q  <= 1'b0;
      img_lo_q <= '0;
      img_hi_q <= '0;
    end else if (en_i) begin
      vstart_q <= vstart_d;
      vstop_q  <= vstop_d;
      hpos_q   <= hpos_d;
      attach_q <= attach_d;
      armed_q  <= armed_d;
      img_lo_q <= img_lo_d;
      img_hi_q <= img_hi_d;
    end
  end

endmodule

// ===== rtl/sdc_out_stage.sv =====
// ----------------------------------------------------------------------------
// sdc_out_stage: result register
// Holds one result transfer until the consumer takes it.
// ----------------------------------------------------------------------------
module sdc_out_stage import sdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  output logic     res_ready_o,
  input  sdc_out_t res_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sdc_out_t out_data_o
);

  logic     valid_q;
  sdc_out_t data_q;

  // Load when empty or when the held result leaves
  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule

// ===== tb/tb_sprite_dma_channel_top.sv =====
// ----------------------------------------------------------------------------
// tb_sprite_dma_channel_top: self-checking bench for one sprite DMA channel
// DMA slots and register writes go through a valid/ready driver. A shadow copy
// of the sprite registers predicts every result, and the monitor checks each
// result transfer field by field. Both sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sprite_dma_channel_top;
  import sdc_pkg::*;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned RandomItems   = 1400;
  localparam int unsigned HoldAfterRes  = 400;
  localparam int unsigned HoldCycles    = 300;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  sdc_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sdc_out_t out_data_o;

  sprite_dma_channel_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Items waiting to be driven and register snapshots waiting to come back
  sdc_in_t  sprite_items[$];
  sdc_out_t expected_sprite_regs[$];
  sdc_out_t predicted_regs;

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  bit          steady_flow   = 1'b0;

  // Shadow sprite registers
  logic [8:0]  shadow_vstart;
  logic [8:0]  shadow_vstop;
  logic [8:0]  shadow_hpos;
  logic        shadow_attach;
  logic        shadow_armed;
  logic [15:0] shadow_image[2];

  // ---------------------------------------------------------------- predictor
  task automatic load_position(input logic [15:0] w);
    shadow_vstart = {shadow_vstart[8], w[15:8]};
    shadow_hpos   = {w[7:0], shadow_hpos[0]};
  endtask

  task automatic load_control(input logic [15:0] w);
    shadow_hpos[0]   = w[0];
    shadow_vstop     = {w[1], w[15:8]};
    shadow_vstart[8] = w[2];
    shadow_attach    = w[7];
    shadow_armed     = 1'b0;
  endtask

  task automatic load_image(input logic idx, input logic [15:0] w);
    shadow_image[idx] = w;
    if (idx == 1'b0) shadow_armed = 1'b1;
  endtask

  task automatic update_sprite_regs(input sdc_in_t item, output sdc_out_t res);
    logic taken;
    taken = 1'b0;
    case (item.action)
      ActDma: begin
        if (item.line == shadow_vstop || item.first_line) begin
          if (item.slot) load_control(item.word);
          else load_position(item.word);
          taken = 1'b1;
        end else begin
          if (item.line == shadow_vstart) shadow_armed = 1'b1;
          if (shadow_armed) begin
            load_image(~item.slot, item.word);
            taken = 1'b1;
          end
        end
      end
      ActPos:  load_position(item.word);
      ActCtrl: load_control(item.word);
      default: load_image(item.slot, item.word);
    endcase
    res.fetch_taken = taken;
    res.armed       = shadow_armed;
    res.attach      = shadow_attach;
    res.horiz_start = shadow_hpos;
    res.image_lo    = shadow_image[0];
    res.image_hi    = shadow_image[1];
  endtask

  // Idle lengths: mostly short, a few long, none during steady stretches
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit and steady/idle phase switching
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (cycle_count % 500 == 0) steady_flow <= ($urandom_range(0, 2) == 0);
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      // predict on every accepted transfer
      if (in_valid_i && in_ready_o) begin
        update_sprite_regs(in_data_i, predicted_regs);
        expected_sprite_regs.push_back(predicted_regs);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (sprite_items.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sprite_items.pop_front();
          send_gap   <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
      hold_left   <= 0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && results_seen >= HoldAfterRes) begin
      // long back-pressure so the channel fills and stalls its input
      out_ready_i <= 1'b0;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else if (recv_stall != 0) begin
      out_ready_i <= 1'b0;
      recv_stall  <= recv_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 30) recv_stall <= draw_gap();
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    sdc_out_t exp_regs;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_sprite_regs.size() == 0) begin
        $error("result transfer with no prediction pending");
        error_count++;
      end else begin
        exp_regs = expected_sprite_regs.pop_front();
        if (out_data_o.fetch_taken !== exp_regs.fetch_taken) begin
          $error("fetch_taken: expected %0d, got %0d",
                 exp_regs.fetch_taken, out_data_o.fetch_taken);
          error_count++;
        end
        if (out_data_o.armed !== exp_regs.armed) begin
          $error("armed: expected %0d, got %0d", exp_regs.armed, out_data_o.armed);
          error_count++;
        end
        if (out_data_o.attach !== exp_regs.attach) begin
          $error("attach: expected %0d, got %0d", exp_regs.attach, out_data_o.attach);
          error_count++;
        end
        if (out_data_o.horiz_start !== exp_regs.horiz_start) begin
          $error("horiz_start: expected %0h, got %0h",
                 exp_regs.horiz_start, out_data_o.horiz_start);
          error_count++;
        end
        if (out_data_o.image_lo !== exp_regs.image_lo) begin
          $error("image_lo: expected %0h, got %0h", exp_regs.image_lo, out_data_o.image_lo);
          error_count++;
        end
        if (out_data_o.image_hi !== exp_regs.image_hi) begin
          $error("image_hi: expected %0h, got %0h", exp_regs.image_hi, out_data_o.image_hi);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_item(input sdc_action_e act, input logic [15:0] w,
                            input logic s, input logic [8:0] ln, input logic first);
    sdc_in_t item;
    item.action     = act;
    item.word       = w;
    item.slot       = s;
    item.line       = ln;
    item.first_line = first;
    sprite_items.push_back(item);
  endtask

  // Fully random item; line sometimes lands on the current start or stop line
  task automatic queue_noise(input logic [8:0] vstart, input logic [8:0] vstop);
    logic [8:0] ln;
    int unsigned pick;
    pick = $urandom_range(0, 3);
    ln = (pick == 0) ? vstart : (pick == 1) ? vstop : 9'($urandom_range(0, 511));
    queue_item(sdc_action_e'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
               1'($urandom_range(0, 1)), ln, ($urandom_range(0, 7) == 0));
  endtask

  // One sprite frame: reload after blanking, lines up to the start, image
  // fetches while visible, then the stop line reload. Returns items queued.
  task automatic queue_frame(output int unsigned counted);
    logic [8:0]  vstart, vstop, hstart, ln;
    logic        attach_bit;
    int unsigned span, lead;
    vstart     = 9'($urandom_range(0, 511));
    span       = $urandom_range(0, 6);
    vstop      = vstart + 9'(span);
    hstart     = 9'($urandom_range(0, 511));
    attach_bit = 1'($urandom_range(0, 1));
    lead       = $urandom_range(0, 3);
    counted    = 0;
    queue_item(ActDma, {vstart[7:0], hstart[8:1]}, 1'b0, 9'($urandom_range(0, 511)), 1'b1);
    queue_item(ActDma, {vstop[7:0], attach_bit, 4'($urandom_range(0, 15)),
                        vstart[8], vstop[8], hstart[0]},
               1'b1, 9'($urandom_range(0, 511)), 1'b1);
    counted += 2;
    for (int k = -int'(lead); k <= int'(span); k++) begin
      ln = vstart + 9'(k);
      for (int s = 0; s < 2; s++) begin
        queue_item(ActDma, 16'($urandom_range(0, 65535)), 1'(s), ln, 1'b0);
        counted++;
      end
      if ($urandom_range(0, 19) == 0) begin
        queue_noise(vstart, vstop);
        counted++;
      end
    end
  endtask

  initial begin
    int unsigned random_count;
    int unsigned frame_count;

    shadow_vstart   = '0;
    shadow_vstop    = '0;
    shadow_hpos     = '0;
    shadow_attach   = 1'b0;
    shadow_armed    = 1'b0;
    shadow_image[0] = '0;
    shadow_image[1] = '0;

    // directed: drop when unarmed, stop line reloads, first line reloads,
    // start line arming, register writes at field extremes
    queue_item(ActDma,   16'hFFFF, 1'b0, 9'd5,   1'b0);
    queue_item(ActDma,   16'h0000, 1'b1, 9'd0,   1'b0);
    queue_item(ActPos,   16'hFFFF, 1'b1, 9'd511, 1'b1);
    queue_item(ActCtrl,  16'hFFFF, 1'b0, 9'd0,   1'b0);
    queue_item(ActDma,   16'h0000, 1'b1, 9'd511, 1'b0);
    queue_item(ActImage, 16'hFFFF, 1'b1, 9'd0,   1'b0);
    queue_item(ActImage, 16'h0000, 1'b0, 9'd511, 1'b1);
    queue_item(ActDma,   16'h1234, 1'b0, 9'd7,   1'b0);
    queue_item(ActCtrl,  16'h0000, 1'b1, 9'd511, 1'b1);
    queue_item(ActDma,   16'hA5A5, 1'b0, 9'd255, 1'b0);
    queue_item(ActDma,   16'h5A5A, 1'b1, 9'd256, 1'b0);
    queue_item(ActDma,   16'hFFFF, 1'b0, 9'd0,   1'b0);
    queue_item(ActDma,   16'h8286, 1'b1, 9'd100, 1'b1);
    queue_item(ActDma,   16'h0000, 1'b0, 9'd200, 1'b1);
    queue_item(ActImage, 16'h0000, 1'b0, 9'd0,   1'b0);
    queue_item(ActDma,   16'hFFFF, 1'b1, 9'd511, 1'b0);
    queue_item(ActPos,   16'h0000, 1'b0, 9'd0,   1'b0);
    queue_item(ActImage, 16'hFFFF, 1'b0, 9'd0,   1'b0);
    queue_item(ActDma,   16'h0000, 1'b0, 9'h082, 1'b0);

    // random: mostly well-formed frames, some noise bursts
    random_count = 0;
    while (random_count < RandomItems) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_frame(frame_count);
        random_count += frame_count;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          queue_noise(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
          random_count++;
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all items sent, all results back, then a quiet tail
    while (sprite_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_sprite_regs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sprite_dma_channel_top.f =====
rtl/sdc_pkg.sv
rtl/sdc_in_stage.sv
rtl/sdc_core.sv
rtl/sdc_out_stage.sv
rtl/sprite_dma_channel_top.sv
tb/tb_sprite_dma_channel_top.sv
